// ===== design/cif_pkg.sv =====
package cif_pkg;

    localparam int LEVEL_BITS = 20;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_SHIFT = FRAC_BITS - 1;
    localparam int VAL_W      = LEVEL_BITS + 2;
    localparam int DIV_STEPS  = FRAC_BITS;
    localparam int PROD_W     = 2 * FRAC_BITS;
    localparam int SUM_W      = FRAC_BITS + 2;
    localparam int NUM_TRI    = 4;

    localparam logic [FRAC_BITS-1:0] FRAC_ONE     = FRAC_BITS'(1) << FRAC_SHIFT;
    localparam logic [FRAC_BITS-1:0] MIN_FRAC_RST = FRAC_BITS'(328);

    typedef enum logic [1:0] {
        TRI_OUTSIDE,
        TRI_INSIDE,
        TRI_MOSTLY_IN,
        TRI_MOSTLY_OUT
    } tri_case_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] mid;
        logic signed [VAL_W-1:0] hi;
    } tri_vals_t;

endpackage

// ===== design/cif_in_if.sv =====
interface cif_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cif_pkg::LEVEL_BITS-1:0] phi_low_left;
    logic signed [cif_pkg::LEVEL_BITS-1:0] phi_low_right;
    logic signed [cif_pkg::LEVEL_BITS-1:0] phi_high_left;
    logic signed [cif_pkg::LEVEL_BITS-1:0] phi_high_right;

    modport source (
        output valid, phi_low_left, phi_low_right, phi_high_left, phi_high_right,
        input  ready
    );
    modport sink (
        input  valid, phi_low_left, phi_low_right, phi_high_left, phi_high_right,
        output ready
    );
endinterface

// ===== design/cif_out_if.sv =====
interface cif_out_if;
    logic                           valid;
    logic                           ready;
    logic [cif_pkg::FRAC_BITS-1:0]  inside_fraction;

    modport source (
        output valid, inside_fraction,
        input  ready
    );
    modport sink (
        input  valid, inside_fraction,
        output ready
    );
endinterface

// ===== design/cif_div_pipe.sv =====
module cif_div_pipe (
    input  logic                           clk,
    input  logic                           en,
    input  logic [cif_pkg::VAL_W-1:0]      num,
    input  logic [cif_pkg::VAL_W-1:0]      den,
    output logic [cif_pkg::FRAC_BITS-1:0]  quo
);
    localparam int W = cif_pkg::VAL_W;
    localparam int S = cif_pkg::DIV_STEPS;

    logic [W-1:0]                  rem_reg [S];
    logic [W-1:0]                  den_reg [S];
    logic [cif_pkg::FRAC_BITS-1:0] quo_reg [S];
    logic [W-1:0]                  rem_next [S];
    logic [cif_pkg::FRAC_BITS-1:0] quo_next [S];

    // restoring division of num * 2^FRAC_SHIFT by den, one quotient bit per stage
    always_comb
    begin
        logic [W:0] trial;
        logic [W:0] diff;
        for (int k = 0; k < S; k++)
        begin
            if (k == 0)
                trial = {1'b0, num};
            else
                trial = {rem_reg[k-1], 1'b0};
            diff = trial - {1'b0, (k == 0) ? den : den_reg[k-1]};
            if (!diff[W])
            begin
                rem_next[k] = diff[W-1:0];
                quo_next[k] = (k == 0) ? cif_pkg::FRAC_BITS'(1)
                                       : {quo_reg[k-1][cif_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[W-1:0];
                quo_next[k] = (k == 0) ? '0
                                       : {quo_reg[k-1][cif_pkg::FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < S; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= (k == 0) ? den : den_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[S-1];
endmodule

// ===== design/cell_inside_fraction_core.sv =====
// channel   dir  words                                   handshake
// in        in   four corner levels, signed Q10.10       valid/ready
// out       out  inside_fraction, Q1.15                  valid/ready
// cfg       in   min_fraction, Q1.15                     write enable only
//
// One word per cycle while not stalled; stages: corner scale, sort, setup,
// 16 divider stages, multiply, sum, clamp. The divider chain sets the depth.
// Reset clears valid bits and sets min_fraction to 328.
// A stalled output is held in a skid register; the pipeline freezes only
// once that register is full, so one more word is taken while a result waits.
module cell_inside_fraction_core (
    input  logic                           clk,
    input  logic                           rst_n,
    cif_in_if.sink                         in,
    cif_out_if.source                      out,
    input  logic                           min_fraction_we,
    input  logic [cif_pkg::FRAC_BITS-1:0]  min_fraction_wdata
);
    localparam int VW = cif_pkg::VAL_W;
    localparam int FB = cif_pkg::FRAC_BITS;
    localparam int NT = cif_pkg::NUM_TRI;
    localparam int DS = cif_pkg::DIV_STEPS;

    logic                  adv;
    logic [FB-1:0]         min_fraction_reg;

    // stage 1: corners x4 and center sum
    logic                  v1_reg;
    logic signed [VW-1:0]  c1_reg [4];
    logic signed [VW-1:0]  ctr1_reg;
    // stage 2: sorted triangles
    logic                  v2_reg;
    cif_pkg::tri_vals_t    tri2_reg [NT];
    cif_pkg::tri_vals_t    tri2_next [NT];
    // stage 3: case, numerator, denominators
    logic                  v3_reg;
    cif_pkg::tri_case_t    case3_reg [NT];
    logic [VW-1:0]         num3_reg [NT];
    logic [VW-1:0]         den3a_reg [NT];
    logic [VW-1:0]         den3b_reg [NT];
    cif_pkg::tri_case_t    case3_next [NT];
    logic [VW-1:0]         num3_next [NT];
    logic [VW-1:0]         den3a_next [NT];
    logic [VW-1:0]         den3b_next [NT];
    // divider alignment
    logic                  vd_reg [DS];
    cif_pkg::tri_case_t    cased_reg [DS][NT];
    logic [FB-1:0]         qa [NT];
    logic [FB-1:0]         qb [NT];
    // multiply
    logic                  vm_reg;
    cif_pkg::tri_case_t    casem_reg [NT];
    logic [cif_pkg::PROD_W-1:0] prod_reg [NT];
    // sum
    logic                  vs_reg;
    logic [cif_pkg::SUM_W-1:0]  sum_reg;
    logic [cif_pkg::SUM_W-1:0]  sum_next;
    logic [FB-1:0]         tfrac [NT];
    // output and skid
    logic                  out_valid_reg;
    logic [FB-1:0]         out_frac_reg;
    logic [FB-1:0]         out_frac_next;
    logic                  skid_full_reg;
    logic [FB-1:0]         skid_frac_reg;

    assign adv      = !skid_full_reg;
    assign in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_fraction_reg <= cif_pkg::MIN_FRAC_RST;
        else if (min_fraction_we)
            min_fraction_reg <= min_fraction_wdata;
    end

    function automatic cif_pkg::tri_vals_t sort3(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b,
        input logic signed [VW-1:0] c
    );
        logic signed [VW-1:0] t;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        cif_pkg::tri_vals_t   r;
        x = a;
        y = b;
        z = c;
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        r.lo  = x;
        r.mid = y;
        r.hi  = z;
        return r;
    endfunction

    // perimeter order: low_left, low_right, high_right, high_left
    always_comb
    begin
        for (int t = 0; t < NT; t++)
            tri2_next[t] = sort3(ctr1_reg, c1_reg[t], c1_reg[(t + 1) % NT]);
    end

    always_comb
    begin
        logic signed [VW:0] d_ca;
        logic signed [VW:0] d_cb;
        logic signed [VW:0] d_ba;
        logic signed [VW:0] neg_a;
        for (int t = 0; t < NT; t++)
        begin
            d_ca  = {tri2_reg[t].hi[VW-1], tri2_reg[t].hi}
                  - {tri2_reg[t].lo[VW-1], tri2_reg[t].lo};
            d_cb  = {tri2_reg[t].hi[VW-1], tri2_reg[t].hi}
                  - {tri2_reg[t].mid[VW-1], tri2_reg[t].mid};
            d_ba  = {tri2_reg[t].mid[VW-1], tri2_reg[t].mid}
                  - {tri2_reg[t].lo[VW-1], tri2_reg[t].lo};
            neg_a = -{tri2_reg[t].lo[VW-1], tri2_reg[t].lo};
            num3_next[t]  = '0;
            den3a_next[t] = VW'(1);
            den3b_next[t] = VW'(1);
            if (!tri2_reg[t].lo[VW-1])
                case3_next[t] = cif_pkg::TRI_OUTSIDE;
            else if (tri2_reg[t].hi[VW-1] || tri2_reg[t].hi == '0)
                case3_next[t] = cif_pkg::TRI_INSIDE;
            else if (tri2_reg[t].mid[VW-1] || tri2_reg[t].mid == '0)
            begin
                case3_next[t] = cif_pkg::TRI_MOSTLY_IN;
                num3_next[t]  = tri2_reg[t].hi;
                den3a_next[t] = d_ca[VW-1:0];
                den3b_next[t] = d_cb[VW-1:0];
            end
            else
            begin
                case3_next[t] = cif_pkg::TRI_MOSTLY_OUT;
                num3_next[t]  = neg_a[VW-1:0];
                den3a_next[t] = d_ba[VW-1:0];
                den3b_next[t] = d_ca[VW-1:0];
            end
        end
    end

    for (genvar t = 0; t < NT; t++)
    begin : g_div
        cif_div_pipe u_div_a (
            .clk (clk), .en (adv), .num (num3_reg[t]), .den (den3a_reg[t]), .quo (qa[t])
        );
        cif_div_pipe u_div_b (
            .clk (clk), .en (adv), .num (num3_reg[t]), .den (den3b_reg[t]), .quo (qb[t])
        );
    end

    always_comb
    begin
        logic [FB-1:0] p;
        sum_next = '0;
        for (int t = 0; t < NT; t++)
        begin
            p = prod_reg[t][cif_pkg::FRAC_SHIFT +: FB];
            unique case (casem_reg[t])
                cif_pkg::TRI_OUTSIDE:    tfrac[t] = '0;
                cif_pkg::TRI_INSIDE:     tfrac[t] = cif_pkg::FRAC_ONE;
                cif_pkg::TRI_MOSTLY_IN:  tfrac[t] = cif_pkg::FRAC_ONE - p;
                cif_pkg::TRI_MOSTLY_OUT: tfrac[t] = p;
                default:                 tfrac[t] = '0;
            endcase
            sum_next = sum_next + cif_pkg::SUM_W'(tfrac[t]);
        end
    end

    always_comb
    begin
        out_frac_next = sum_reg[cif_pkg::SUM_W-1:2];
        if (out_frac_next < min_fraction_reg)
            out_frac_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            vs_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DS; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vd_reg[0]     <= v3_reg;
            for (int k = 1; k < DS; k++)
                vd_reg[k] <= vd_reg[k-1];
            vm_reg        <= vd_reg[DS-1];
            vs_reg        <= vm_reg;
            out_valid_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else if (skid_full_reg && out.ready)
            skid_full_reg <= 1'b0;
        else if (!skid_full_reg && out_valid_reg && !out.ready)
            skid_full_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && out_valid_reg && !out.ready)
            skid_frac_reg <= out_frac_reg;
        if (adv)
        begin
            c1_reg[0] <= {in.phi_low_left, 2'b00};
            c1_reg[1] <= {in.phi_low_right, 2'b00};
            c1_reg[2] <= {in.phi_high_right, 2'b00};
            c1_reg[3] <= {in.phi_high_left, 2'b00};
            ctr1_reg  <= VW'(in.phi_low_left) + VW'(in.phi_low_right)
                       + VW'(in.phi_high_left) + VW'(in.phi_high_right);
            for (int t = 0; t < NT; t++)
            begin
                tri2_reg[t]     <= tri2_next[t];
                case3_reg[t]    <= case3_next[t];
                num3_reg[t]     <= num3_next[t];
                den3a_reg[t]    <= den3a_next[t];
                den3b_reg[t]    <= den3b_next[t];
                cased_reg[0][t] <= case3_reg[t];
                for (int k = 1; k < DS; k++)
                    cased_reg[k][t] <= cased_reg[k-1][t];
                casem_reg[t]    <= cased_reg[DS-1][t];
                prod_reg[t]     <= cif_pkg::PROD_W'(qa[t]) * cif_pkg::PROD_W'(qb[t]);
            end
            sum_reg      <= sum_next;
            out_frac_reg <= out_frac_next;
        end
    end

    assign out.valid           = skid_full_reg || out_valid_reg;
    assign out.inside_fraction = skid_full_reg ? skid_frac_reg : out_frac_reg;

`ifndef SYNTHESIS
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> out.inside_fraction <= cif_pkg::FRAC_ONE)
        else $error("inside_fraction above one");
    a_skid_stall: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> !in.ready)
        else $error("input taken while skid full");
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && !out.ready) |=> (skid_full_reg && $stable(skid_frac_reg)))
        else $error("skid word lost");
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        vs_reg |-> sum_reg <= cif_pkg::SUM_W'(cif_pkg::FRAC_ONE) * 4)
        else $error("triangle sum out of range");
`endif
endmodule
